### src/svcs_pkg.sv
// svcs_pkg: shared types, constants and helpers of the sparse voxel chunk store
// used by every module of the block but svcs_ram; no dependencies
`default_nettype none
package svcs_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int POOL_CHUNKS  = 1024;

  localparam int CHUNK_VOXELS = 512;
  localparam int VOX_W        = $clog2(CHUNK_VOXELS);
  localparam int DIR_DEPTH    = (MAX_WIDTH / 8) * (MAX_WIDTH / 8) * (MAX_HEIGHT / 8);
  localparam int DIR_AW       = $clog2(DIR_DEPTH);
  localparam int SLOT_W       = $clog2(POOL_CHUNKS);
  localparam int FREE_CNT_W   = SLOT_W + 1;
  localparam int DIR_PW       = (SLOT_W > 8) ? SLOT_W : 8;
  localparam int DIR_W        = 2 + DIR_PW;
  localparam int POOL_AW      = SLOT_W + VOX_W;
  localparam int POOL_W       = 9;
  localparam int SUP_W        = DIR_AW - 3;
  localparam int M1_W         = 10;
  localparam int INIT_DEPTH   = (DIR_DEPTH > POOL_CHUNKS) ? DIR_DEPTH : POOL_CHUNKS;
  localparam int INIT_W       = $clog2(INIT_DEPTH);

  localparam int EXT_W        = 9;
  localparam int CAP_W        = (MAX_WIDTH / 64) * 64;
  localparam int CAP_H        = (MAX_HEIGHT / 64) * 64;

  localparam int Q_DEPTH      = 2;
  localparam int QP_W         = $clog2(Q_DEPTH);

  localparam int CFG_IW       = 1;
  localparam logic [CFG_IW-1:0] CFG_WORLD_WIDTH  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_WORLD_HEIGHT = 1'd1;

  localparam logic [1:0] TAG_EMPTY   = 2'b00;
  localparam logic [1:0] TAG_MIXED   = 2'b10;
  localparam logic [1:0] TAG_UNIFORM = 2'b11;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_RANGE
  } svcs_cmd_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] pos_z;
    logic [7:0] write_value;
  } svcs_in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] status;
  } svcs_out_t;

  typedef struct packed {
    logic [EXT_W-1:0] world_width;
    logic [EXT_W-1:0] world_height;
  } svcs_cfg_t;

  typedef struct packed {
    svcs_cmd_t         cmd;
    logic [DIR_AW-1:0] cidx;
    logic [VOX_W-1:0]  vidx;
    logic [7:0]        value;
  } svcs_entry_t;

  typedef struct packed {
    logic                  init_done;
    logic [FREE_CNT_W-1:0] free_count;
  } svcs_bstat_t;

  function automatic logic [EXT_W-1:0] svcs_eff_extent(input logic [EXT_W-1:0] r,
                                                        input int cap);
    logic [EXT_W-1:0] v;
    v = {r[EXT_W-1:6], 6'd0};
    if (int'(v) < 64) v = EXT_W'(64);
    if (int'(v) > cap) v = EXT_W'(cap);
    return v;
  endfunction

endpackage
`default_nettype wire

### src/svcs_ram.sv
// svcs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module svcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

### src/svcs_front.sv
// svcs_front: accepts items, checks range and works out chunk and voxel index
// depends on svcs_pkg
`default_nettype none
module svcs_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire svcs_pkg::svcs_cfg_t  cfg,
  input  wire logic                 init_done,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire svcs_pkg::svcs_in_t   in_data,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output svcs_pkg::svcs_entry_t     push_data
);
  import svcs_pkg::*;

  logic [EXT_W-1:0] w_eff;
  logic [EXT_W-1:0] h_eff;
  logic             range_err;
  logic [M1_W-1:0]  m1;
  logic [SUP_W-1:0] super_idx;

  logic             s1_v_r;
  svcs_cmd_t        s1_cmd_r;
  logic [M1_W-1:0]  s1_m1_r;
  logic [3:0]       s1_y_hi_r;
  logic [2:0]       s1_bits_r;
  logic [VOX_W-1:0] s1_vidx_r;
  logic [7:0]       s1_value_r;

  assign w_eff = svcs_eff_extent(cfg.world_width, CAP_W);
  assign h_eff = svcs_eff_extent(cfg.world_height, CAP_H);

  assign range_err = ({1'b0, in_data.pos_x} >= w_eff) || ({1'b0, in_data.pos_z} >= w_eff) ||
                     ({1'b0, in_data.pos_y} >= h_eff);
  assign m1 = M1_W'(in_data.pos_x[7:4]) * M1_W'(w_eff[EXT_W-1:4]) + M1_W'(in_data.pos_z[7:4]);

  assign in_ready = init_done && (!s1_v_r || push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (push_ready) begin
      s1_v_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      if (range_err) begin
        s1_cmd_r <= CMD_RANGE;
      end else if (in_data.operation == OP_WRITE) begin
        s1_cmd_r <= CMD_WRITE;
      end else begin
        s1_cmd_r <= CMD_READ;
      end
      s1_m1_r    <= m1;
      s1_y_hi_r  <= in_data.pos_y[7:4];
      s1_bits_r  <= {in_data.pos_x[3], in_data.pos_z[3], in_data.pos_y[3]};
      s1_vidx_r  <= {in_data.pos_x[2:0], in_data.pos_z[2:0], in_data.pos_y[2:0]};
      s1_value_r <= in_data.write_value;
    end
  end

  assign super_idx = SUP_W'(SUP_W'(s1_m1_r) * SUP_W'(h_eff[EXT_W-1:4]) + SUP_W'(s1_y_hi_r));

  assign push_valid      = s1_v_r;
  assign push_data.cmd   = s1_cmd_r;
  assign push_data.cidx  = {super_idx, s1_bits_r};
  assign push_data.vidx  = s1_vidx_r;
  assign push_data.value = s1_value_r;
endmodule
`default_nettype wire

### src/svcs_queue.sv
// svcs_queue: short register fifo between front and back
// depends on svcs_pkg
`default_nettype none
module svcs_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  input  wire svcs_pkg::svcs_entry_t push_data,
  output logic                       pop_valid,
  input  wire logic                  pop,
  output svcs_pkg::svcs_entry_t      pop_data,
  output logic [svcs_pkg::QP_W:0]    count
);
  import svcs_pkg::*;

  svcs_entry_t     mem_r [Q_DEPTH];
  logic [QP_W-1:0] wp_r;
  logic [QP_W-1:0] rp_r;
  logic [QP_W:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (cnt_r != (QP_W + 1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign count      = cnt_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

### src/svcs_back.sv
// svcs_back: directory, voxel pool and free list sequencer with result register
// depends on svcs_pkg and svcs_ram
`default_nettype none
module svcs_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_pop,
  input  wire svcs_pkg::svcs_entry_t q_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output svcs_pkg::svcs_out_t        out_data,
  output svcs_pkg::svcs_bstat_t      bstat
);
  import svcs_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DIR, S_PREAD, S_FL, S_FILL, S_SCAN, S_EMIT
  } state_t;

  state_t                state_r;
  logic [INIT_W-1:0]     icnt_r;
  logic [FREE_CNT_W-1:0] free_cnt_r;
  svcs_entry_t           it_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [7:0]            old_r;
  logic [VOX_W:0]        cnt_r;
  logic                  rv_r;
  logic [VOX_W-1:0]      ridx_r;
  logic [7:0]            first_r;
  svcs_out_t             res_r;
  logic                  out_valid_r;
  svcs_out_t             out_data_r;

  logic                  dir_we;
  logic [DIR_AW-1:0]     dir_waddr;
  logic [DIR_W-1:0]      dir_wdata;
  logic [DIR_AW-1:0]     dir_raddr;
  logic [DIR_W-1:0]      dir_rdata;
  logic                  pool_we;
  logic [POOL_AW-1:0]    pool_waddr;
  logic [POOL_W-1:0]     pool_wdata;
  logic [POOL_AW-1:0]    pool_raddr;
  logic [POOL_W-1:0]     pool_rdata;
  logic                  fl_we;
  logic [SLOT_W-1:0]     fl_waddr;
  logic [SLOT_W-1:0]     fl_wdata;
  logic [SLOT_W-1:0]     fl_raddr;
  logic [SLOT_W-1:0]     fl_rdata;

  logic [1:0]            dtag;
  logic [DIR_PW-1:0]     dpay;
  logic [7:0]            old_val;
  logic [7:0]            pval;
  logic [7:0]            first_sel;
  logic                  eq;
  logic                  scan_last;
  logic                  can_free;
  logic                  fill_last;
  logic [FREE_CNT_W-1:0] free_dec;

  svcs_ram #(.WIDTH(DIR_W), .DEPTH(DIR_DEPTH)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );
  svcs_ram #(.WIDTH(POOL_W), .DEPTH(POOL_CHUNKS * CHUNK_VOXELS)) u_pool (
    .clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(pool_wdata),
    .raddr(pool_raddr), .rdata(pool_rdata)
  );
  svcs_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_CHUNKS)) u_free (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );

  assign dtag      = dir_rdata[DIR_W-1 -: 2];
  assign dpay      = dir_rdata[DIR_PW-1:0];
  assign old_val   = (dtag == TAG_UNIFORM) ? dpay[7:0] : 8'd0;
  assign pval      = pool_rdata[7:0];
  assign first_sel = (ridx_r == '0) ? pval : first_r;
  assign eq        = (pval == first_sel);
  assign scan_last = rv_r && (ridx_r == VOX_W'(CHUNK_VOXELS - 1));
  assign can_free  = (int'(free_cnt_r) < POOL_CHUNKS);
  assign fill_last = (cnt_r[VOX_W-1:0] == VOX_W'(CHUNK_VOXELS - 1));
  assign free_dec  = free_cnt_r - 1'b1;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign bstat.init_done  = (state_r != S_INIT);
  assign bstat.free_count = free_cnt_r;

  always_comb begin
    dir_we     = 1'b0;
    dir_waddr  = it_r.cidx;
    dir_wdata  = '0;
    dir_raddr  = q_data.cidx;
    pool_we    = 1'b0;
    pool_waddr = {slot_r, it_r.vidx};
    pool_wdata = {it_r.value != 8'd0, it_r.value};
    pool_raddr = {slot_r, cnt_r[VOX_W-1:0]};
    fl_we      = 1'b0;
    fl_waddr   = free_cnt_r[SLOT_W-1:0];
    fl_wdata   = slot_r;
    fl_raddr   = free_dec[SLOT_W-1:0];
    case (state_r)
      S_INIT: begin
        dir_we    = (int'(icnt_r) < DIR_DEPTH);
        dir_waddr = icnt_r[DIR_AW-1:0];
        fl_we     = (int'(icnt_r) < POOL_CHUNKS);
        fl_waddr  = icnt_r[SLOT_W-1:0];
        fl_wdata  = SLOT_W'(POOL_CHUNKS - 1) - icnt_r[SLOT_W-1:0];
      end
      S_DIR: begin
        pool_raddr = {dpay[SLOT_W-1:0], it_r.vidx};
        if (it_r.cmd == CMD_WRITE && dtag == TAG_MIXED) begin
          pool_we    = 1'b1;
          pool_waddr = {dpay[SLOT_W-1:0], it_r.vidx};
        end
      end
      S_FILL: begin
        pool_we    = 1'b1;
        pool_waddr = {slot_r, cnt_r[VOX_W-1:0]};
        if (cnt_r[VOX_W-1:0] != it_r.vidx) begin
          pool_wdata = {old_r != 8'd0, old_r};
        end
        if (fill_last) begin
          dir_we    = 1'b1;
          dir_wdata = {TAG_MIXED, DIR_PW'(slot_r)};
        end
      end
      S_SCAN: begin
        if (scan_last && eq && can_free) begin
          fl_we     = 1'b1;
          dir_we    = 1'b1;
          dir_wdata = {(first_sel != 8'd0) ? TAG_UNIFORM : TAG_EMPTY, DIR_PW'(first_sel)};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      icnt_r      <= '0;
      free_cnt_r  <= FREE_CNT_W'(POOL_CHUNKS);
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          icnt_r <= icnt_r + 1'b1;
          if (icnt_r == INIT_W'(INIT_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            it_r <= q_data;
            if (q_data.cmd == CMD_RANGE || q_data.cmd == CMD_READ ||
                q_data.cmd == CMD_WRITE) begin
              if (q_data.cmd == CMD_RANGE) begin
                res_r   <= '{read_value: 8'd0, status: ST_RANGE};
                state_r <= S_EMIT;
              end else begin
                state_r <= S_DIR;
              end
            end else begin
              res_r   <= '{read_value: 8'd0, status: ST_OK};
              state_r <= S_EMIT;
            end
          end
        end
        S_DIR: begin
          res_r <= '{read_value: 8'd0, status: ST_OK};
          if (it_r.cmd == CMD_READ) begin
            if (dtag == TAG_MIXED) begin
              state_r <= S_PREAD;
            end else begin
              res_r   <= '{read_value: old_val, status: ST_OK};
              state_r <= S_EMIT;
            end
          end else if (dtag == TAG_MIXED) begin
            slot_r  <= dpay[SLOT_W-1:0];
            cnt_r   <= '0;
            rv_r    <= 1'b0;
            state_r <= S_SCAN;
          end else if (old_val == it_r.value) begin
            state_r <= S_EMIT;
          end else if (free_cnt_r == '0) begin
            res_r   <= '{read_value: 8'd0, status: ST_FULL};
            state_r <= S_EMIT;
          end else begin
            old_r      <= old_val;
            free_cnt_r <= free_dec;
            state_r    <= S_FL;
          end
        end
        S_PREAD: begin
          res_r   <= '{read_value: pval, status: ST_OK};
          state_r <= S_EMIT;
        end
        S_FL: begin
          slot_r  <= fl_rdata;
          cnt_r   <= '0;
          state_r <= S_FILL;
        end
        S_FILL: begin
          cnt_r <= cnt_r + 1'b1;
          if (fill_last) begin
            state_r <= S_EMIT;
          end
        end
        S_SCAN: begin
          if (!cnt_r[VOX_W]) begin
            cnt_r  <= cnt_r + 1'b1;
            rv_r   <= 1'b1;
            ridx_r <= cnt_r[VOX_W-1:0];
          end else begin
            rv_r <= 1'b0;
          end
          if (rv_r && ridx_r == '0) begin
            first_r <= pval;
          end
          if (rv_r && !eq) begin
            rv_r    <= 1'b0;
            state_r <= S_EMIT;
          end else if (scan_last) begin
            rv_r <= 1'b0;
            if (can_free) begin
              free_cnt_r <= free_cnt_r + 1'b1;
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    if (state_r == S_EMIT && (!out_valid_r || out_ready)) begin
      out_data_r <= res_r;
    end
  end
endmodule
`default_nettype wire

### src/sparse_voxel_chunk_store.sv
// sparse_voxel_chunk_store: a write to a mixed chunk is followed by a uniformity
// scan of up to 512 voxels through the pool read port, an allocating write by a
// 512-voxel slot fill through the pool write port; after reset a clearing pass
// empties the directory and loads the free list; no item is taken during it,
// configuration writes are taken at any time
`default_nettype none
module sparse_voxel_chunk_store (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire svcs_pkg::svcs_in_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output svcs_pkg::svcs_out_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [svcs_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [svcs_pkg::EXT_W-1:0]    cfg_data
);
  import svcs_pkg::*;

  svcs_cfg_t     cfg_r;
  svcs_bstat_t   bstat;
  logic          push_valid;
  logic          push_ready;
  svcs_entry_t   push_data;
  logic          q_valid;
  logic          q_pop;
  svcs_entry_t   q_data;
  logic [QP_W:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.world_width  <= EXT_W'(256);
      cfg_r.world_height <= EXT_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WORLD_WIDTH:  cfg_r.world_width  <= cfg_data;
        CFG_WORLD_HEIGHT: cfg_r.world_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  svcs_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .init_done(bstat.init_done),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  svcs_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_data), .count(q_count)
  );

  svcs_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .bstat(bstat)
  );

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !bstat.init_done |-> !in_ready)
    else $error("item taken during clearing pass");

  a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(bstat.free_count) <= POOL_CHUNKS)
    else $error("free count beyond pool size");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(q_count) <= Q_DEPTH)
    else $error("queue overfilled");

  a_free_moves_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.init_done && $past(bstat.init_done) |->
      (bstat.free_count == $past(bstat.free_count)) ||
      (bstat.free_count == $past(bstat.free_count) + 1'b1) ||
      (bstat.free_count == $past(bstat.free_count) - 1'b1))
    else $error("free count jumped");
endmodule
`default_nettype wire

### test/tb.sv
// tb: self-checking bench for sparse_voxel_chunk_store, with voxel reads and writes,
// chunk collapse and world extent changes checked against a local model
// depends on svcs_pkg and the sparse_voxel_chunk_store rtl
`default_nettype none
module tb;
  import svcs_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  svcs_in_t  in_data;
  svcs_out_t out_data;
  logic [CFG_IW-1:0] cfg_index;
  logic [EXT_W-1:0]  cfg_data;

  sparse_voxel_chunk_store i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // voxel store model
  logic [1:0] chunk_tag [int];
  int         chunk_slot [int];
  logic [7:0] pool_vox [int];
  int         free_list [POOL_CHUNKS];
  int         free_cnt;
  int         eff_w, eff_h;

  svcs_in_t  pending_items [$];
  svcs_out_t expected_results [$];
  int        items_sent, results_seen, errors;
  int        n_read, n_write, n_range, n_full, n_collapse;
  int        gap, stall, hold_cnt;
  bit        hold_done;

  function automatic int clamp_extent(int r);
    int v;
    v = r & ~63;
    if (v < 64) v = 64;
    if (v > 256) v = 256;
    return v;
  endfunction

  function automatic svcs_out_t voxel_access(svcs_in_t it);
    svcs_out_t  r;
    int         x, y, z, sup, cidx, vidx, slot, base, i;
    logic [1:0] tag;
    logic [7:0] old, u;
    bit         same;
    r = '0;
    x = it.pos_x; y = it.pos_y; z = it.pos_z;
    if (x >= eff_w || z >= eff_w || y >= eff_h) begin
      r.status = ST_RANGE;
      return r;
    end
    sup = ((x >> 4) * (eff_w >> 4) + (z >> 4)) * (eff_h >> 4) + (y >> 4);
    cidx = (sup << 3) + (((x >> 3) & 1) << 2) + (((z >> 3) & 1) << 1) + ((y >> 3) & 1);
    if (cidx >= DIR_DEPTH) begin
      r.status = ST_RANGE;
      return r;
    end
    vidx = (x & 7) * 64 + (z & 7) * 8 + (y & 7);
    tag = chunk_tag.exists(cidx) ? chunk_tag[cidx] : TAG_EMPTY;
    if (it.operation == OP_READ) begin
      if (tag == TAG_UNIFORM) r.read_value = chunk_slot[cidx][7:0];
      else if (tag == TAG_MIXED) r.read_value = pool_vox[chunk_slot[cidx] * 512 + vidx];
      return r;
    end
    if (tag == TAG_MIXED) begin
      slot = chunk_slot[cidx];
      base = slot * 512;
      pool_vox[base + vidx] = it.write_value;
      same = 1;
      for (i = 1; i < 512; i++)
        if (pool_vox[base + i] != pool_vox[base]) begin
          same = 0;
          break;
        end
      if (same && free_cnt < POOL_CHUNKS) begin
        u = pool_vox[base];
        free_list[free_cnt] = slot;
        free_cnt++;
        chunk_tag[cidx] = (u != 0) ? TAG_UNIFORM : TAG_EMPTY;
        chunk_slot[cidx] = u;
        n_collapse++;
      end
      return r;
    end
    old = (tag == TAG_UNIFORM) ? chunk_slot[cidx][7:0] : 8'd0;
    if (old == it.write_value) return r;
    if (free_cnt == 0) begin
      r.status = ST_FULL;
      return r;
    end
    free_cnt--;
    slot = free_list[free_cnt];
    for (i = 0; i < 512; i++) pool_vox[slot * 512 + i] = old;
    pool_vox[slot * 512 + vidx] = it.write_value;
    chunk_tag[cidx] = TAG_MIXED;
    chunk_slot[cidx] = slot;
    return r;
  endfunction

  task automatic queue_item(logic op, int x, int y, int z, int v);
    svcs_in_t  it;
    svcs_out_t r;
    it.operation = op;
    it.pos_x = x[7:0]; it.pos_y = y[7:0]; it.pos_z = z[7:0];
    it.write_value = v[7:0];
    r = voxel_access(it);
    if (r.status == ST_RANGE) n_range++;
    else if (r.status == ST_FULL) n_full++;
    else if (op == OP_READ) n_read++;
    else n_write++;
    pending_items.push_back(it);
    expected_results.push_back(r);
  endtask

  function automatic logic [7:0] peek_voxel(int x, int y, int z);
    svcs_in_t it;
    svcs_out_t r;
    it = '0;
    it.operation = OP_READ;
    it.pos_x = x[7:0]; it.pos_y = y[7:0]; it.pos_z = z[7:0];
    r = voxel_access(it);
    return r.read_value;
  endfunction

  task automatic drain();
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_extent(logic [CFG_IW-1:0] idx, int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[EXT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WORLD_WIDTH) eff_w = clamp_extent(val);
    else eff_h = clamp_extent(val);
  endtask

  task automatic random_phase(int n);
    int hx, hy, hz, k, x, y, z, v, sel;
    int hist_x [$], hist_y [$], hist_z [$], hist_v [$];
    hx = $urandom_range(0, eff_w - 16);
    hy = $urandom_range(0, eff_h - 16);
    hz = $urandom_range(0, eff_w - 16);
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      x = hx + $urandom_range(0, 15);
      y = hy + $urandom_range(0, 15);
      z = hz + $urandom_range(0, 15);
      if (sel < 35) begin
        queue_item(OP_READ, x, y, z, $urandom_range(0, 255));
      end else if (sel < 70) begin
        case ($urandom_range(0, 2))
          0: v = 0;
          1: v = 8'h5A;
          default: v = $urandom_range(0, 255);
        endcase
        hist_x.push_back(x); hist_y.push_back(y); hist_z.push_back(z);
        hist_v.push_back(peek_voxel(x, y, z));
        queue_item(OP_WRITE, x, y, z, v);
      end else if (sel < 88 && hist_x.size() > 0) begin
        // undo the latest write so the chunk can fall back to uniform
        queue_item(OP_WRITE, hist_x.pop_back(), hist_y.pop_back(), hist_z.pop_back(),
                   hist_v.pop_back());
      end else begin
        queue_item(1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap      <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) items_sent <= items_sent + 1;
      if (gap > 0) begin
        gap      <= gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        gap      <= ((items_sent / 50) % 3 == 2) ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && items_sent == 60) begin
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    int        nstall;
    svcs_out_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall     <= 0;
    end else begin
      nstall = (stall > 0) ? stall - 1 : 0;
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual value %0d status %0d", $time,
                   out_data.read_value, out_data.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.read_value !== out_data.read_value) begin
            $display("%0t: read_value mismatch, expected %0d actual %0d", $time,
                     exp_r.read_value, out_data.read_value);
            errors++;
          end
          if (exp_r.status !== out_data.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time,
                     exp_r.status, out_data.status);
            errors++;
          end
        end
        nstall = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 13);
      end
      stall     <= nstall;
      out_ready <= (hold_cnt == 0) && (nstall == 0);
    end
  end

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #24000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    items_sent = 0; results_seen = 0; errors = 0;
    n_read = 0; n_write = 0; n_range = 0; n_full = 0; n_collapse = 0;
    eff_w = 256; eff_h = 256;
    for (i = 0; i < POOL_CHUNKS; i++) free_list[i] = POOL_CHUNKS - 1 - i;
    free_cnt = POOL_CHUNKS;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners at full extent
    queue_item(OP_READ, 0, 0, 0, 0);
    queue_item(OP_WRITE, 255, 255, 255, 255);
    queue_item(OP_READ, 255, 255, 255, 0);
    queue_item(OP_READ, 255, 255, 254, 0);
    queue_item(OP_WRITE, 255, 255, 254, 0);
    queue_item(OP_WRITE, 255, 255, 255, 0);
    queue_item(OP_READ, 255, 255, 255, 0);
    queue_item(OP_WRITE, 0, 0, 0, 0);
    queue_item(OP_WRITE, 128, 7, 64, 1);
    queue_item(OP_READ, 128, 7, 64, 0);
    queue_item(OP_READ, 129, 7, 64, 0);
    drain();

    // break an empty chunk and let it collapse back
    queue_item(OP_WRITE, 3, 3, 3, 8'h11);
    queue_item(OP_READ, 3, 3, 3, 0);
    queue_item(OP_READ, 3, 3, 4, 0);
    queue_item(OP_WRITE, 3, 3, 3, 0);
    queue_item(OP_READ, 3, 3, 3, 0);
    random_phase(130);
    drain();

    write_extent(CFG_WORLD_WIDTH, 64);
    write_extent(CFG_WORLD_HEIGHT, 64);
    queue_item(OP_READ, 64, 0, 0, 0);
    queue_item(OP_WRITE, 0, 64, 0, 9);
    queue_item(OP_WRITE, 63, 63, 63, 9);
    random_phase(80);
    drain();

    write_extent(CFG_WORLD_WIDTH, 200);
    write_extent(CFG_WORLD_HEIGHT, 130);
    random_phase(80);
    drain();

    write_extent(CFG_WORLD_WIDTH, 0);
    write_extent(CFG_WORLD_HEIGHT, 511);
    random_phase(80);
    drain();

    $display("covered %0d reads, %0d writes, %0d out-of-range and %0d pool-full items",
             n_read, n_write, n_range, n_full);
    $display("%0d chunk collapses, %0d results checked, %0d mismatches",
             n_collapse, results_seen, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
src/svcs_pkg.sv
src/svcs_ram.sv
src/svcs_front.sv
src/svcs_queue.sv
src/svcs_back.sv
src/sparse_voxel_chunk_store.sv
test/tb.sv
